>>> sv/jts_pkg.sv
// shared types, codes and helpers for the json token scanner
`default_nettype none

package jts_pkg;

	localparam int PositionBits = 32;
	localparam int QueueDepth   = 4;
	localparam int CountBits    = 3;
	localparam int SlotCount    = 4;

	// token kinds
	localparam logic [3:0] KindEnd     = 4'd0;
	localparam logic [3:0] KindError   = 4'd1;
	localparam logic [3:0] KindLBrace  = 4'd2;
	localparam logic [3:0] KindLBrack  = 4'd3;
	localparam logic [3:0] KindRBrace  = 4'd4;
	localparam logic [3:0] KindRBrack  = 4'd5;
	localparam logic [3:0] KindComma   = 4'd6;
	localparam logic [3:0] KindColon   = 4'd7;
	localparam logic [3:0] KindSemi    = 4'd8;
	localparam logic [3:0] KindString  = 4'd9;
	localparam logic [3:0] KindNumber  = 4'd10;
	localparam logic [3:0] KindTrue    = 4'd11;
	localparam logic [3:0] KindFalse   = 4'd12;
	localparam logic [3:0] KindNull    = 4'd13;

	// keyword selection
	localparam logic [1:0] KwTrue  = 2'd0;
	localparam logic [1:0] KwFalse = 2'd1;
	localparam logic [1:0] KwNull  = 2'd2;

	// source bytes
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChLBrace = 8'h7B;
	localparam logic [7:0] ChLBrack = 8'h5B;
	localparam logic [7:0] ChRBrace = 8'h7D;
	localparam logic [7:0] ChRBrack = 8'h5D;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChSemi   = 8'h3B;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChLowE   = 8'h65;
	localparam logic [7:0] ChUpE    = 8'h45;
	localparam logic [7:0] ChLowT   = 8'h74;
	localparam logic [7:0] ChLowF   = 8'h66;
	localparam logic [7:0] ChLowN   = 8'h6E;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] ChLowU   = 8'h75;
	localparam logic [7:0] ChLowA   = 8'h61;
	localparam logic [7:0] ChLowL   = 8'h6C;
	localparam logic [7:0] ChLowS   = 8'h73;

	typedef enum logic [3:0] {
		ModeIdle  = 4'd0,
		ModeKw    = 4'd1,
		ModeStr   = 4'd2,
		ModeNSign = 4'd3,
		ModeNInt  = 4'd4,
		ModeNZero = 4'd5,
		ModeNFrac = 4'd6,
		ModeNExpS = 4'd7,
		ModeNExp  = 4'd8
	} mode_t;

	// one record: four slots of kind, start, length and repeat count
	function automatic int rec_bits(input int pos_bits);
		return SlotCount * (4 + 2 * pos_bits + CountBits);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= ChZero) && (b <= ChNine);
	endfunction

	// letters after the first one of each keyword
	function automatic logic [7:0] kw_char(input logic [1:0] choice, input logic [1:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (choice)
			KwTrue: begin
				unique case (idx)
					2'd0: c = ChLowR;
					2'd1: c = ChLowU;
					2'd2: c = ChLowE;
					default: c = 8'h00;
				endcase
			end
			KwFalse: begin
				unique case (idx)
					2'd0: c = ChLowA;
					2'd1: c = ChLowL;
					2'd2: c = ChLowS;
					default: c = ChLowE;
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: c = ChLowU;
					2'd1: c = ChLowL;
					2'd2: c = ChLowL;
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] choice);
		return (choice == KwFalse) ? 3'd4 : 3'd3;
	endfunction

	function automatic logic [3:0] kw_kind(input logic [1:0] choice);
		logic [3:0] k;
		unique case (choice)
			KwTrue:  k = KindTrue;
			KwFalse: k = KindFalse;
			default: k = KindNull;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

>>> sv/jts_front.sv
// scanner front end: classifies each byte and packs the tokens it causes into a record
`default_nettype none

module jts_front import jts_pkg::*; #(
	parameter int POSITION_BITS = PositionBits
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 take,
	input  wire logic [7:0]                           data_byte,
	input  wire logic                                 final_byte,
	output logic                                      rec_valid,
	output logic [rec_bits(POSITION_BITS)-1:0]        rec_data
);

	localparam int PW = POSITION_BITS;

	typedef struct packed {
		logic [3:0]           kind;
		logic [PW-1:0]        start;
		logic [PW-1:0]        len;
		logic [CountBits-1:0] count;
	} slot_t;

	typedef slot_t [SlotCount-1:0] rec_t;

	mode_t         mode_q, mode_d;
	logic [PW-1:0] pos_q, pos_next;
	logic [PW-1:0] origin_q, origin_d;
	logic [1:0]    choice_q, choice_d;
	logic [1:0]    prog_q, prog_d;
	logic          bs_q, bs_d;
	logic          rescan;
	logic [PW-1:0] feed_len, flush_len;
	logic [2:0]    prog_inc;
	rec_t          rec;

	assign pos_next  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign feed_len  = pos_q - origin_q;
	assign flush_len = pos_next - origin_d;
	assign prog_inc  = {1'b0, prog_q} + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ModeIdle;
			pos_q    <= '0;
			origin_q <= '0;
			choice_q <= KwTrue;
			prog_q   <= '0;
			bs_q     <= 1'b0;
		end else if (take) begin
			if (final_byte) begin
				// a new text starts at offset zero
				mode_q   <= ModeIdle;
				pos_q    <= '0;
				origin_q <= '0;
				choice_q <= KwTrue;
				prog_q   <= '0;
				bs_q     <= 1'b0;
			end else begin
				mode_q   <= mode_d;
				pos_q    <= pos_next;
				origin_q <= origin_d;
				choice_q <= choice_d;
				prog_q   <= prog_d;
				bs_q     <= bs_d;
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		origin_d = origin_q;
		choice_d = choice_q;
		prog_d   = prog_q;
		bs_d     = bs_q;
		rescan   = 1'b0;
		rec      = '0;

		// slot 0: token closed by this byte, or the errors of a failed keyword
		unique case (mode_q)
			ModeKw: begin
				if (data_byte == kw_char(choice_q, prog_q)) begin
					if (prog_inc >= kw_len(choice_q)) begin
						rec[0] = '{kind: kw_kind(choice_q), start: origin_q,
							len: PW'(kw_len(choice_q)) + PW'(1), count: 3'd1};
						mode_d = ModeIdle;
						prog_d = '0;
					end else begin
						prog_d = prog_inc[1:0];
					end
				end else begin
					rec[0] = '{kind: KindError, start: origin_q, len: PW'(1), count: prog_inc};
					prog_d = '0;
					rescan = 1'b1;
				end
			end
			ModeStr: begin
				if (data_byte == ChQuote && !bs_q) begin
					rec[0] = '{kind: KindString, start: origin_q, len: feed_len, count: 3'd1};
					mode_d = ModeIdle;
				end
				bs_d = (data_byte == ChBslash);
			end
			ModeNSign: begin
				mode_d = (data_byte == ChZero) ? ModeNZero : ModeNInt;
			end
			ModeNInt, ModeNZero: begin
				if (mode_q == ModeNInt && is_digit(data_byte)) begin
					mode_d = ModeNInt;
				end else if (data_byte == ChDot) begin
					mode_d = ModeNFrac;
				end else if (data_byte == ChLowE || data_byte == ChUpE) begin
					mode_d = ModeNExpS;
				end else begin
					rescan = 1'b1;
				end
			end
			ModeNFrac: begin
				if (is_digit(data_byte)) begin
					mode_d = ModeNFrac;
				end else if (data_byte == ChLowE || data_byte == ChUpE) begin
					mode_d = ModeNExpS;
				end else begin
					rescan = 1'b1;
				end
			end
			ModeNExpS: begin
				if (data_byte == ChPlus || data_byte == ChMinus || is_digit(data_byte)) begin
					mode_d = ModeNExp;
				end else begin
					rescan = 1'b1;
				end
			end
			ModeNExp: begin
				if (!is_digit(data_byte)) begin
					rescan = 1'b1;
				end
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		// a number ends at a foreign byte
		if (rescan && mode_q >= ModeNSign) begin
			rec[0] = '{kind: KindNumber, start: origin_q, len: feed_len, count: 3'd1};
		end

		// slot 1: the byte scanned between tokens
		if (rescan) begin
			mode_d = ModeIdle;
			unique case (data_byte) inside
				ChSpace, ChTab, ChCr, ChLf: begin
				end
				ChLBrace: rec[1] = '{kind: KindLBrace, start: pos_q, len: PW'(1), count: 3'd1};
				ChLBrack: rec[1] = '{kind: KindLBrack, start: pos_q, len: PW'(1), count: 3'd1};
				ChRBrace: rec[1] = '{kind: KindRBrace, start: pos_q, len: PW'(1), count: 3'd1};
				ChRBrack: rec[1] = '{kind: KindRBrack, start: pos_q, len: PW'(1), count: 3'd1};
				ChComma:  rec[1] = '{kind: KindComma, start: pos_q, len: PW'(1), count: 3'd1};
				ChColon:  rec[1] = '{kind: KindColon, start: pos_q, len: PW'(1), count: 3'd1};
				ChSemi:   rec[1] = '{kind: KindSemi, start: pos_q, len: PW'(1), count: 3'd1};
				ChLowT, ChLowF, ChLowN: begin
					mode_d   = ModeKw;
					choice_d = (data_byte == ChLowT) ? KwTrue :
						(data_byte == ChLowF) ? KwFalse : KwNull;
					prog_d   = '0;
					origin_d = pos_q;
				end
				ChQuote: begin
					mode_d   = ModeStr;
					origin_d = pos_next;
					bs_d     = 1'b0;
				end
				ChMinus: begin
					mode_d   = ModeNSign;
					origin_d = pos_q;
				end
				[ChZero:ChNine]: begin
					mode_d   = (data_byte == ChZero) ? ModeNZero : ModeNInt;
					origin_d = pos_q;
				end
				default: rec[1] = '{kind: KindError, start: pos_q, len: PW'(1), count: 3'd1};
			endcase
		end

		// slots 2 and 3: flush of a pending token and the end mark
		if (final_byte) begin
			if (mode_d == ModeKw) begin
				rec[2] = '{kind: KindError, start: origin_d, len: PW'(1),
					count: {1'b0, prog_d} + 3'd1};
			end else if (mode_d == ModeStr) begin
				rec[2] = '{kind: KindString, start: origin_d, len: flush_len, count: 3'd1};
			end else if (mode_d >= ModeNSign) begin
				rec[2] = '{kind: KindNumber, start: origin_d, len: flush_len, count: 3'd1};
			end
			rec[3] = '{kind: KindEnd, start: pos_next, len: '0, count: 3'd1};
		end
	end

	assign rec_data  = rec;
	assign rec_valid = take && ((rec[0].count != '0) || (rec[1].count != '0) ||
		(rec[2].count != '0) || (rec[3].count != '0));

endmodule

`default_nettype wire

>>> sv/jts_queue.sv
// short record queue between scanner front end and token back end
`default_nettype none

module jts_queue import jts_pkg::*; #(
	parameter int DATA_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [DATA_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	output logic [DATA_BITS-1:0]      rd_data,
	output logic                      full,
	output logic                      empty
);

	localparam int PtrBits = $clog2(QueueDepth);
	localparam int CntBits = $clog2(QueueDepth + 1);

	logic [DATA_BITS-1:0] mem [QueueDepth];
	logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntBits-1:0]   count_q;
	logic                 do_wr, do_rd;

	assign full    = (count_q == CntBits'(QueueDepth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/jts_back.sv
// token back end: walks each record into the result register, one token per cycle while that is free or popped
`default_nettype none

module jts_back import jts_pkg::*; #(
	parameter int POSITION_BITS = PositionBits
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rec_ready,
	input  wire logic [rec_bits(POSITION_BITS)-1:0]   rec_data,
	output logic                                      rec_pop,
	input  wire logic                                 pop,
	output logic                                      empty,
	output logic [3:0]                                token_kind,
	output logic [31:0]                               token_start,
	output logic [31:0]                               token_length,
	output logic                                      last_token
);

	localparam int PW = POSITION_BITS;

	typedef struct packed {
		logic [3:0]           kind;
		logic [PW-1:0]        start;
		logic [PW-1:0]        len;
		logic [CountBits-1:0] count;
	} slot_t;

	typedef slot_t [SlotCount-1:0] rec_t;

	rec_t                 rec;
	logic [1:0]           slot_q, cur, nxt;
	logic [CountBits-1:0] sub_q;
	logic [PW-1:0]        run_start_q, tok_start;
	logic                 has_later, more_in_slot, last, issue;
	logic                 out_valid_q;
	logic [3:0]           kind_q;
	logic [PW-1:0]        start_q, len_q;
	logic                 last_q;

	assign rec = rec_data;

	// first slot with tokens left, and the one after it
	always_comb begin
		cur       = slot_q;
		nxt       = slot_q;
		has_later = 1'b0;
		for (int i = SlotCount - 1; i >= 0; i--) begin
			if (2'(i) >= slot_q && rec[i].count != '0) begin
				cur = 2'(i);
			end
		end
		for (int i = SlotCount - 1; i >= 0; i--) begin
			if (2'(i) > cur && rec[i].count != '0) begin
				has_later = 1'b1;
				nxt       = 2'(i);
			end
		end
	end

	// error runs step their start by one, stopping at the top
	assign tok_start    = (sub_q == '0) ? rec[cur].start : run_start_q;
	assign more_in_slot = (sub_q + 3'd1) < rec[cur].count;
	assign last         = !more_in_slot && !has_later;
	assign issue        = rec_ready && (!out_valid_q || pop);
	assign rec_pop      = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				if (more_in_slot) begin
					sub_q <= sub_q + 3'd1;
				end else if (has_later) begin
					slot_q <= nxt;
					sub_q  <= '0;
				end else begin
					slot_q <= '0;
					sub_q  <= '0;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			run_start_q <= (tok_start == '1) ? tok_start : tok_start + 1'b1;
			kind_q      <= rec[cur].kind;
			start_q     <= tok_start;
			len_q       <= rec[cur].len;
			last_q      <= last;
		end
	end

	assign empty        = !out_valid_q;
	assign token_kind   = kind_q;
	assign token_start  = 32'(start_q);
	assign token_length = 32'(len_q);
	assign last_token   = last_q;

endmodule

`default_nettype wire

>>> sv/json_token_scanner.sv
// json token scanner top level: front end, record queue and back end
// throughput: one byte per cycle while the record queue has room; the back end gives
//   one token per cycle while its result register is free or popped
// result: the result register takes a token in the cycle after the edge that accepts the
//   byte closing it, when the queue and result register are otherwise empty
// reset: arst_n clears scanner state, byte position, queue pointers and the result valid flag
`default_nettype none

module json_token_scanner import jts_pkg::*; #(
	parameter int POSITION_BITS = PositionBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       token_kind,
	output logic [31:0]      token_start,
	output logic [31:0]      token_length,
	output logic             last_token
);

	localparam int RecBits = rec_bits(POSITION_BITS);

	logic               take;
	logic               rec_valid;
	logic [RecBits-1:0] rec_in, rec_head;
	logic               q_full, q_empty, rec_pop;

	assign full = q_full;
	assign take = push && !q_full;

	jts_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.rec_valid (rec_valid),
		.rec_data  (rec_in)
	);

	jts_queue #(
		.DATA_BITS(RecBits)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_valid),
		.wr_data(rec_in),
		.rd_en  (rec_pop),
		.rd_data(rec_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	jts_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_ready   (!q_empty),
		.rec_data    (rec_head),
		.rec_pop     (rec_pop),
		.pop         (pop),
		.empty       (empty),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.last_token  (last_token)
	);

endmodule

`default_nettype wire

>>> tb/tb_json_token_scanner.sv
// self-checking testbench for the json token scanner: random json texts, token checks
`timescale 1ns / 100ps

module tb_json_token_scanner;
	import jts_pkg::*;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [31:0] len;
		logic        last;
	} token_t;

	typedef logic [PositionBits-1:0] pos_t;

	class token_ledger;
		token_t tokens_due[$];
		token_t fresh[$];
		mode_t  mode;
		pos_t   pos;
		pos_t   origin;
		logic [1:0] kw_sel;
		logic [1:0] kw_got;
		logic   escaped;
		int     errors;
		int     checked;
		logic [15:0] kinds_seen;

		function new();
			clear();
			errors = 0;
			checked = 0;
			kinds_seen = '0;
		endfunction

		function void clear();
			mode = ModeIdle;
			pos = '0;
			origin = '0;
			kw_sel = KwTrue;
			kw_got = '0;
			escaped = 1'b0;
		endfunction

		// position arithmetic sticks at all ones
		function pos_t bump(pos_t a, pos_t b);
			logic [PositionBits:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[PositionBits] ? '1 : s[PositionBits-1:0];
		endfunction

		function void emit(logic [3:0] kind, pos_t start, pos_t len);
			token_t t;
			if (fresh.size() >= 6)
				return;
			t.kind = kind;
			t.start = start[31:0];
			t.len = len[31:0];
			t.last = 1'b0;
			fresh.push_back(t);
		endfunction

		// letters of the keyword after its first one
		function string spelling(logic [1:0] sel);
			if (sel == KwTrue)
				return "rue";
			if (sel == KwFalse)
				return "alse";
			return "ull";
		endfunction

		function void keyword_errors();
			for (int i = 0; i <= kw_got; i++)
				emit(KindError, bump(origin, pos_t'(i)), 1);
		endfunction

		function void start_token(logic [7:0] b, pos_t p, pos_t nxt);
			mode = ModeIdle;
			case (b)
				ChSpace, ChTab, ChCr, ChLf: ;
				ChLBrace: emit(KindLBrace, p, 1);
				ChLBrack: emit(KindLBrack, p, 1);
				ChRBrace: emit(KindRBrace, p, 1);
				ChRBrack: emit(KindRBrack, p, 1);
				ChComma:  emit(KindComma, p, 1);
				ChColon:  emit(KindColon, p, 1);
				ChSemi:   emit(KindSemi, p, 1);
				ChLowT, ChLowF, ChLowN: begin
					mode = ModeKw;
					kw_sel = (b == ChLowT) ? KwTrue : (b == ChLowF) ? KwFalse : KwNull;
					kw_got = '0;
					origin = p;
				end
				ChQuote: begin
					mode = ModeStr;
					origin = nxt;
					escaped = 1'b0;
				end
				ChMinus: begin
					mode = ModeNSign;
					origin = p;
				end
				default: begin
					if (b >= ChZero && b <= ChNine) begin
						mode = (b == ChZero) ? ModeNZero : ModeNInt;
						origin = p;
					end else begin
						emit(KindError, p, 1);
					end
				end
			endcase
		endfunction

		function void step(logic [7:0] b, pos_t p, pos_t nxt);
			string sp;
			mode_t nm;
			logic ends;
			logic digit;
			logic in_number;
			sp = spelling(kw_sel);
			nm = mode;
			ends = 1'b0;
			digit = (b >= ChZero) && (b <= ChNine);
			in_number = (mode >= ModeNInt) && (mode <= ModeNExp);
			case (mode)
				ModeKw: begin
					if (b == sp[kw_got]) begin
						if (kw_got + 1 >= sp.len()) begin
							emit((kw_sel == KwTrue) ? KindTrue :
								(kw_sel == KwFalse) ? KindFalse : KindNull,
								origin, pos_t'(sp.len() + 1));
							mode = ModeIdle;
							kw_got = '0;
						end else begin
							kw_got = kw_got + 2'd1;
						end
					end else begin
						keyword_errors();
						kw_got = '0;
						start_token(b, p, nxt);
					end
				end
				ModeStr: begin
					if (b == ChQuote && !escaped) begin
						emit(KindString, origin, p - origin);
						mode = ModeIdle;
					end
					escaped = (b == ChBslash);
				end
				ModeNSign: mode = (b == ChZero) ? ModeNZero : ModeNInt;
				ModeNInt, ModeNZero: begin
					if (mode == ModeNInt && digit)
						nm = ModeNInt;
					else if (b == ChDot)
						nm = ModeNFrac;
					else if (b == ChLowE || b == ChUpE)
						nm = ModeNExpS;
					else
						ends = 1'b1;
				end
				ModeNFrac: begin
					if (digit)
						nm = ModeNFrac;
					else if (b == ChLowE || b == ChUpE)
						nm = ModeNExpS;
					else
						ends = 1'b1;
				end
				ModeNExpS: begin
					if (b == ChPlus || b == ChMinus || digit)
						nm = ModeNExp;
					else
						ends = 1'b1;
				end
				ModeNExp: begin
					if (!digit)
						ends = 1'b1;
				end
				default: start_token(b, p, nxt);
			endcase
			if (in_number) begin
				// the byte that ends a number is scanned again from idle
				if (ends) begin
					emit(KindNumber, origin, p - origin);
					start_token(b, p, nxt);
				end else begin
					mode = nm;
				end
			end
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			pos_t p;
			pos_t nxt;
			token_t t;
			p = pos;
			nxt = bump(p, 1);
			fresh.delete();
			step(b, p, nxt);
			if (fin) begin
				if (mode == ModeKw)
					keyword_errors();
				else if (mode == ModeStr)
					emit(KindString, origin, nxt - origin);
				else if (mode >= ModeNSign && mode <= ModeNExp)
					emit(KindNumber, origin, nxt - origin);
				emit(KindEnd, nxt, 0);
				clear();
			end else begin
				pos = nxt;
			end
			if (fresh.size() > 0) begin
				t = fresh.pop_back();
				t.last = 1'b1;
				fresh.push_back(t);
			end
			foreach (fresh[i])
				tokens_due.push_back(fresh[i]);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_token(logic [3:0] kind, logic [31:0] start, logic [31:0] len,
				logic last);
			token_t want;
			if (tokens_due.size() == 0) begin
				report($sformatf("unexpected token kind %0d start %0d len %0d",
					kind, start, len));
			end else begin
				want = tokens_due.pop_front();
				checked++;
				kinds_seen[kind] = 1'b1;
				if (kind !== want.kind)
					report($sformatf("kind %0d, want %0d", kind, want.kind));
				if (start !== want.start)
					report($sformatf("start %0d, want %0d (kind %0d)", start, want.start,
						want.kind));
				if (len !== want.len)
					report($sformatf("length %0d, want %0d (kind %0d)", len, want.len,
						want.kind));
				if (last !== want.last)
					report($sformatf("last mark %b, want %b (kind %0d)", last, want.last,
						want.kind));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic        last_token;

	token_ledger ledger = new();
	logic [7:0] text_q[$];
	bit idle_on = 1'b1;
	bit sender_gaps = 1'b1;
	bit hold_request = 1'b0;
	int stall_left = 0;
	int bytes_sent = 0;
	int texts = 0;
	int full_stalls = 0;

	json_token_scanner dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.empty       (empty),
		.pop         (pop),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.last_token  (last_token)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// token side: check each popped token, stall in bursts or on a long hold
	initial begin
		forever begin
			@(posedge clk);
			if (pop && !empty)
				ledger.check_token(token_kind, token_start, token_length, last_token);
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 299;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 12);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function void add_chars(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// append one random lexical fragment, mostly well formed
	function void grow_text();
		string word;
		int n;
		case ($urandom_range(0, 15))
			0, 1, 15: begin
				word = " \t\r\n";
				text_q.push_back(word[$urandom_range(0, 3)]);
			end
			2, 3, 4: begin
				word = "{[}],:;";
				text_q.push_back(word[$urandom_range(0, 6)]);
			end
			5, 6, 7: begin
				n = $urandom_range(0, 2);
				word = (n == 0) ? "true" : (n == 1) ? "false" : "null";
				// a broken keyword stops after a prefix
				if ($urandom_range(0, 2) == 0)
					word = word.substr(0, $urandom_range(0, word.len() - 2));
				add_chars(word);
			end
			8, 9: begin
				text_q.push_back(ChQuote);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 3))
						0: add_chars("\\\"");
						1: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
						2: text_q.push_back(ChBslash);
						default: text_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				if ($urandom_range(0, 7) != 0)
					text_q.push_back(ChQuote);
			end
			10, 11, 12: begin
				if ($urandom_range(0, 2) == 0)
					text_q.push_back(ChMinus);
				if ($urandom_range(0, 3) == 0) begin
					text_q.push_back(ChZero);
				end else begin
					text_q.push_back(ChZero + 8'($urandom_range(1, 9)));
					repeat ($urandom_range(0, 3))
						text_q.push_back(ChZero + 8'($urandom_range(0, 9)));
				end
				if ($urandom_range(0, 1) == 0) begin
					text_q.push_back(ChDot);
					repeat ($urandom_range(0, 3))
						text_q.push_back(ChZero + 8'($urandom_range(0, 9)));
				end
				if ($urandom_range(0, 1) == 0) begin
					text_q.push_back($urandom_range(0, 1) ? ChLowE : ChUpE);
					n = $urandom_range(0, 2);
					if (n != 0)
						text_q.push_back((n == 1) ? ChPlus : ChMinus);
					repeat ($urandom_range(0, 3))
						text_q.push_back(ChZero + 8'($urandom_range(0, 9)));
				end
			end
			13: text_q.push_back(8'($urandom_range(0, 255)));
			default: begin
				// the byte after a minus is always part of the number
				text_q.push_back(ChMinus);
				text_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	task send_byte(logic [7:0] b, logic fin);
		push <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		ledger.note_byte(b, fin);
		bytes_sent++;
		if (idle_on && sender_gaps && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task send_text();
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
		texts++;
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// punctuation, escaped quote inside a string, signed number with fraction and exponent
		add_chars("{\"a\\\"\":-0.5e+3}");
		send_text();
		// failed keyword, unknown bytes, zero ended by a quote, string cut by the last byte
		add_chars("[tru");
		text_q.push_back(8'hFF);
		text_q.push_back(8'h00);
		add_chars("null;0\"x");
		send_text();

		while (bytes_sent < 380) begin
			target = $urandom_range(1, 30);
			sender_gaps = $urandom_range(0, 3) != 0;
			if (texts == 5) begin
				// long hold on the token side while bytes keep coming
				target = 40;
				sender_gaps = 1'b0;
				hold_request = 1'b1;
			end
			if (bytes_sent > 320)
				idle_on = 1'b0;
			while (text_q.size() < target)
				grow_text();
			send_text();
		end
		push <= 1'b0;

		while (ledger.tokens_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("scanned %0d texts, %0d bytes; %0d tokens checked, kinds seen %b",
			texts, bytes_sent, ledger.checked, ledger.kinds_seen[13:0]);
		$display("input held by a full queue on %0d cycles, %0d mismatches",
			full_stalls, ledger.errors);
		if (ledger.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
